// ===== rtl/dmxfe_pkg.sv =====
package dmxfe_pkg;

  localparam int SLOT_W      = 10;
  localparam int BYTE_W      = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_TX_DONE = 2'd1,
    CMD_HOST_WR = 2'd2,
    CMD_HOST_RD = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 1'b0,
    REG_MAX_TX = 1'b1
  } reg_e;

  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TX  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RX  = 2'd2;

  typedef enum logic [3:0] {
    PH_BREAK = 4'b0001,
    PH_START = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_IDLE  = 4'b1000
  } phase_e;

  typedef struct packed {
    cmd_e              command;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_error;
    logic [SLOT_W-1:0] slot_index;
    logic [BYTE_W-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_break_format;
    logic              frame_done;
    logic [SLOT_W-1:0] frame_slots;
    logic [BYTE_W-1:0] read_data;
  } out_t;

  // One classified item: store access plus the result fields known up front
  typedef struct packed {
    logic              we;
    logic              tx_rd;
    logic              host_rd;
    logic [SLOT_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
    logic              tx_valid;
    logic              tx_brk;
    logic              frame_done;
    logic [SLOT_W-1:0] frame_slots;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/dmxfe_front.sv =====
module dmxfe_front #(
  parameter int MAX_SLOTS = 512,
  parameter int MIN_SLOTS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  dmxfe_pkg::in_t                     item_i,
  input  logic                               cfg_we_i,
  input  logic [dmxfe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dmxfe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output dmxfe_pkg::op_t                     op_o
);
  import dmxfe_pkg::*;

  localparam logic [SLOT_W-1:0] MaxSlots = SLOT_W'(MAX_SLOTS);
  localparam logic [SLOT_W-1:0] MinSlots = SLOT_W'(MIN_SLOTS);

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [SLOT_W-1:0] max_tx_q, max_tx_d;
  phase_e            phase_q, phase_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] cnt_inc;
  logic [SLOT_W-1:0] sat_slots;
  logic [MODE_W-1:0] new_mode;
  op_t               op;

  assign cnt_inc  = cnt_q + SLOT_W'(1);
  assign new_mode = cfg_data_i[MODE_W-1:0];

  always_comb begin
    if (cfg_data_i < MinSlots) begin
      sat_slots = MinSlots;
    end else if (cfg_data_i > MaxSlots) begin
      sat_slots = MaxSlots;
    end else begin
      sat_slots = cfg_data_i;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    max_tx_d = max_tx_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    op       = '0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE: begin
          mode_d = new_mode;
          if (new_mode == MODE_TX && mode_q != MODE_TX) begin
            phase_d = PH_BREAK;
          end else if (new_mode == MODE_RX && mode_q != MODE_RX) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end
        end
        REG_MAX_TX: max_tx_d = sat_slots;
        default: ;
      endcase
    end else if (accept_i) begin
      unique case (item_i.command)
        CMD_RX_BYTE: begin
          if (mode_q == MODE_RX) begin
            if (item_i.frame_error) begin
              // break: report whatever part of a frame came in
              phase_d = PH_BREAK;
              if (cnt_q != '0) begin
                op.frame_done  = 1'b1;
                op.frame_slots = cnt_q;
              end
              cnt_d = '0;
            end else begin
              unique case (phase_q)
                PH_BREAK: begin
                  if (item_i.rx_byte == '0) begin
                    phase_d = PH_DATA;
                    cnt_d   = SLOT_W'(1);
                  end else begin
                    phase_d = PH_IDLE;
                  end
                end
                PH_DATA: begin
                  if (cnt_q <= MaxSlots) begin
                    op.we    = 1'b1;
                    op.addr  = cnt_q;
                    op.wdata = item_i.rx_byte;
                  end
                  cnt_d = cnt_inc;
                  if (cnt_inc > MaxSlots || cnt_inc == '0) begin
                    phase_d = PH_IDLE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        CMD_TX_DONE: begin
          if (mode_q == MODE_TX) begin
            unique case (phase_q)
              PH_BREAK: begin
                op.tx_valid = 1'b1;
                op.tx_brk   = 1'b1;
                phase_d     = PH_START;
              end
              PH_START: begin
                op.tx_valid = 1'b1;
                op.tx_rd    = 1'b1;
                op.addr     = '0;
                cnt_d       = SLOT_W'(1);
                phase_d     = PH_DATA;
              end
              PH_DATA: begin
                op.tx_valid = 1'b1;
                op.tx_rd    = (cnt_q <= MaxSlots);
                op.addr     = cnt_q;
                cnt_d       = cnt_inc;
                if (cnt_inc > max_tx_q || cnt_inc == '0) begin
                  phase_d = PH_BREAK;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_HOST_WR: begin
          if (item_i.slot_index <= MaxSlots) begin
            op.we    = 1'b1;
            op.addr  = item_i.slot_index;
            op.wdata = item_i.write_value;
          end
        end
        CMD_HOST_RD: begin
          op.host_rd = (item_i.slot_index <= MaxSlots);
          op.addr    = item_i.slot_index;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      max_tx_q <= MaxSlots;
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      max_tx_q <= max_tx_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
    end
  end

  assign op_o = op;

endmodule

// ===== rtl/dmxfe_queue.sv =====
module dmxfe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dmxfe_pkg::op_t        data_i,
  input  logic                  pop_i,
  output dmxfe_pkg::op_t        data_o,
  output dmxfe_pkg::q_status_t  status_o
);
  import dmxfe_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  op_t             entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: ;
      endcase
    end
  end

  assign data_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

// ===== rtl/dmxfe_back.sv =====
module dmxfe_back #(
  parameter int MAX_SLOTS = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmxfe_pkg::q_status_t  q_status_i,
  input  dmxfe_pkg::op_t        op_i,
  output logic                  pop_o,
  output logic                  clr_busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dmxfe_pkg::out_t       out_data_o
);
  import dmxfe_pkg::*;

  localparam int Depth = MAX_SLOTS + 1;
  localparam int AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_SLOTS);

  logic [BYTE_W-1:0] slot_mem_q [Depth];
  logic [BYTE_W-1:0] rd_q;
  op_t               op_q;
  logic              out_valid_q;
  logic              clr_busy_q;
  logic [AddrW-1:0]  clr_addr_q;
  logic              issue;
  logic [AddrW-1:0]  mem_addr;

  // advance when not clearing, the queue holds an item and the output register is free or is being taken
  assign issue    = !clr_busy_q && !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign mem_addr = op_i.addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      slot_mem_q[clr_addr_q] <= '0;
    end else if (issue && op_i.we) begin
      slot_mem_q[mem_addr] <= op_i.wdata;
    end
    if (issue && (op_i.tx_rd || op_i.host_rd)) begin
      rd_q <= slot_mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  assign pop_o       = issue;
  assign clr_busy_o  = clr_busy_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.tx_valid        = op_q.tx_valid;
    out_data_o.tx_byte         = op_q.tx_rd ? rd_q : '0;
    out_data_o.tx_break_format = op_q.tx_brk;
    out_data_o.frame_done      = op_q.frame_done;
    out_data_o.frame_slots     = op_q.frame_slots;
    out_data_o.read_data       = op_q.host_rd ? rd_q : '0;
  end

endmodule

// ===== rtl/dmx512_frame_engine.sv =====
// Channel  | Handshake                | Payload
// ---------+--------------------------+----------------------------------------
// in       | in_valid_i / in_stall_o  | in_data_i   (command, line byte, host op)
// out      | out_valid_o / out_stall_i| out_data_o  (tx byte, frame report, read)
// cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i stays low and no configuration
// write comes in; a result passes through a queue slot, then the slot store read
// into the output register, from which it can leave.
// After reset all MAX_SLOTS + 1 slot store entries are zeroed, one per cycle,
// while in_stall_o stays high; configuration writes are taken throughout, and a
// cycle that takes one holds off the input.
// The two-entry queue lets input take one more item while the output register
// is stalled.
module dmx512_frame_engine #(
  parameter int MAX_SLOTS = 512,
  parameter int MIN_SLOTS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dmxfe_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dmxfe_pkg::out_t                   out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dmxfe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dmxfe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dmxfe_pkg::*;

  logic      in_accept;
  logic      cfg_we;
  logic      q_pop;
  logic      clr_busy;
  op_t       front_op;
  op_t       q_op;
  q_status_t q_status;

  // hold input while clearing the store, when the queue is full, or while a register write goes through
  assign in_stall_o  = clr_busy || q_status.full || cfg_we;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  dmxfe_front #(
    .MAX_SLOTS (MAX_SLOTS),
    .MIN_SLOTS (MIN_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_o        (front_op)
  );

  dmxfe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_accept),
    .data_i   (front_op),
    .pop_i    (q_pop),
    .data_o   (q_op),
    .status_o (q_status)
  );

  dmxfe_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .op_i        (q_op),
    .pop_o       (q_pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy) |-> !out_valid_o)
    else $error("result present at end of store clearing");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_done) |-> (out_data_o.frame_slots != '0))
    else $error("frame reported with zero slots");

  a_break_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.tx_break_format) |->
      (out_data_o.tx_valid && out_data_o.tx_byte == '0))
    else $error("break format without a zero tx byte");

endmodule

// ===== tb/tb_dmx512_frame_engine.sv =====
`timescale 1ns / 100ps

module tb_dmx512_frame_engine;
  import dmxfe_pkg::*;

  localparam int MAX_SLOTS = 512;
  localparam int MIN_SLOTS = 24;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dmx512_frame_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Engine image: slot store, sequencing and registers
  logic [BYTE_W-1:0] slot_image [0:MAX_SLOTS] = '{default: 8'h00};
  phase_e            eng_phase     = PH_IDLE;
  logic [SLOT_W-1:0] slot_cnt      = '0;
  logic [MODE_W-1:0] eng_mode      = MODE_OFF;
  logic [SLOT_W-1:0] tx_slot_limit = 10'd512;

  out_t        expected_results [$];
  out_t        want;
  int unsigned mismatches = 0;

  int src_max_gap       = 14;
  int sink_max_wait     = 14;
  int sink_hold_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("dmx512_frame_engine regression: fail");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] read_slot(logic [SLOT_W-1:0] idx);
    return (idx > MAX_SLOTS) ? 8'h00 : slot_image[idx];
  endfunction

  function automatic void apply_reg_write(reg_e idx, logic [CFG_DATA_W-1:0] data);
    logic [MODE_W-1:0] m;
    m = data[MODE_W-1:0];
    case (idx)
      REG_MODE: begin
        if (m == MODE_TX && eng_mode != MODE_TX) begin
          eng_phase = PH_BREAK;
        end else if (m == MODE_RX && eng_mode != MODE_RX) begin
          eng_phase = PH_IDLE;
          slot_cnt = '0;
        end
        eng_mode = m;
      end
      default: begin
        if (data < MIN_SLOTS) tx_slot_limit = SLOT_W'(MIN_SLOTS);
        else if (data > MAX_SLOTS) tx_slot_limit = SLOT_W'(MAX_SLOTS);
        else tx_slot_limit = data;
      end
    endcase
  endfunction

  function automatic out_t engine_step(in_t item);
    out_t r;
    r = '0;
    case (item.command)
      CMD_RX_BYTE: begin
        if (eng_mode == MODE_RX) begin
          if (item.frame_error) begin
            // break ends any partial frame
            eng_phase = PH_BREAK;
            if (slot_cnt != 0) begin
              r.frame_done  = 1'b1;
              r.frame_slots = slot_cnt;
            end
            slot_cnt = '0;
          end else if (eng_phase == PH_BREAK) begin
            if (item.rx_byte == 8'h00) begin
              eng_phase = PH_DATA;
              slot_cnt  = 10'd1;
            end else begin
              eng_phase = PH_IDLE;
            end
          end else if (eng_phase == PH_DATA) begin
            if (slot_cnt <= MAX_SLOTS) slot_image[slot_cnt] = item.rx_byte;
            slot_cnt = slot_cnt + 10'd1;
            if (slot_cnt > MAX_SLOTS || slot_cnt == 0) eng_phase = PH_IDLE;
          end
        end
      end
      CMD_TX_DONE: begin
        if (eng_mode == MODE_TX) begin
          case (eng_phase)
            PH_BREAK: begin
              r.tx_valid        = 1'b1;
              r.tx_break_format = 1'b1;
              eng_phase         = PH_START;
            end
            PH_START: begin
              r.tx_valid = 1'b1;
              r.tx_byte  = slot_image[0];
              slot_cnt   = 10'd1;
              eng_phase  = PH_DATA;
            end
            PH_DATA: begin
              r.tx_valid = 1'b1;
              r.tx_byte  = read_slot(slot_cnt);
              slot_cnt   = slot_cnt + 10'd1;
              if (slot_cnt > tx_slot_limit || slot_cnt == 0) eng_phase = PH_BREAK;
            end
            default: ;
          endcase
        end
      end
      CMD_HOST_WR: begin
        if (item.slot_index <= MAX_SLOTS) slot_image[item.slot_index] = item.write_value;
      end
      default: r.read_data = read_slot(item.slot_index);
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [SLOT_W-1:0] exp_v,
                                      logic [SLOT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Predict on every accepted item, check every accepted result
  always @(posedge clk_i) begin
    if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
      expected_results.push_back(engine_step(in_data_i));
    end
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: %p", out_data_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("tx_valid", SLOT_W'(want.tx_valid), SLOT_W'(out_data_o.tx_valid));
        check_field("tx_byte", SLOT_W'(want.tx_byte), SLOT_W'(out_data_o.tx_byte));
        check_field("tx_break_format", SLOT_W'(want.tx_break_format),
                    SLOT_W'(out_data_o.tx_break_format));
        check_field("frame_done", SLOT_W'(want.frame_done),
                    SLOT_W'(out_data_o.frame_done));
        check_field("frame_slots", want.frame_slots, out_data_o.frame_slots);
        check_field("read_data", SLOT_W'(want.read_data), SLOT_W'(out_data_o.read_data));
      end
    end
  end

  // Result side: random stall per item, or a long counted hold on request
  initial begin
    int pause;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else begin
        pause = $urandom_range(sink_max_wait, 0);
        if (pause > 0) begin
          out_stall_i <= 1'b1;
          repeat (pause) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        @(posedge clk_i);
        while (out_valid_o !== 1'b1 && sink_hold_cycles == 0) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(in_t item);
    int gap;
    gap = $urandom_range(src_max_gap, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_reg_write(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_t rand_item(cmd_e c);
    in_t it;
    it.command     = c;
    it.rx_byte     = 8'($urandom);
    it.frame_error = 1'($urandom_range(1, 0));
    it.slot_index  = ($urandom_range(7, 0) == 0) ? 10'($urandom)
                                                 : 10'($urandom_range(MAX_SLOTS, 0));
    it.write_value = 8'($urandom);
    return it;
  endfunction

  task automatic send_rx(logic [BYTE_W-1:0] b, logic err);
    in_t it;
    it = rand_item(CMD_RX_BYTE);
    it.rx_byte     = b;
    it.frame_error = err;
    send_item(it);
  endtask

  task automatic send_tx_done();
    send_item(rand_item(CMD_TX_DONE));
  endtask

  task automatic send_host(cmd_e c, logic [SLOT_W-1:0] idx, logic [BYTE_W-1:0] val);
    in_t it;
    it = rand_item(c);
    it.slot_index  = idx;
    it.write_value = val;
    send_item(it);
  endtask

  task automatic send_host_random();
    send_item(rand_item($urandom_range(1, 0) ? CMD_HOST_WR : CMD_HOST_RD));
  endtask

  task automatic test_host_access();
    send_host(CMD_HOST_WR, 10'd0, 8'hA5);
    send_host(CMD_HOST_WR, 10'd512, 8'hFF);
    send_host(CMD_HOST_WR, 10'd513, 8'h5A);
    send_host(CMD_HOST_WR, 10'd1023, 8'h00);
    send_host(CMD_HOST_RD, 10'd0, 8'h00);
    send_host(CMD_HOST_RD, 10'd512, 8'h00);
    send_host(CMD_HOST_RD, 10'd513, 8'h00);
    send_host(CMD_HOST_RD, 10'd1023, 8'hFF);
    // line events while disabled
    send_rx(8'hFF, 1'b1);
    send_tx_done();
    wait_drained();
    write_reg(REG_MODE, 10'd3);
    send_rx(8'h00, 1'b1);
    send_tx_done();
    wait_drained();
  endtask

  task automatic test_tx_directed();
    write_reg(REG_MAX_TX, 10'd0);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_TX));
    send_rx(8'h00, 1'b1);
    repeat (4) send_tx_done();
    wait_drained();
  endtask

  task automatic test_rx_directed();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_RX));
    send_tx_done();
    send_rx(8'h55, 1'b0);
    send_rx(8'h00, 1'b1);
    send_rx(8'h17, 1'b0);
    send_rx(8'h42, 1'b0);
    send_rx(8'h80, 1'b1);
    send_rx(8'h00, 1'b0);
    send_rx(8'hFF, 1'b0);
    send_rx(8'h01, 1'b0);
    send_rx(8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_rx_frames();
    int len;
    // same mode with upper bits set: sequencing must hold
    write_reg(REG_MODE, {8'hFF, MODE_RX});
    for (int f = 0; f < 6; f++) begin
      send_rx(8'($urandom), 1'b1);
      if ($urandom_range(3, 0) == 0) send_rx(8'($urandom), 1'b1);
      send_rx(($urandom_range(5, 0) == 0) ? 8'($urandom_range(255, 1)) : 8'h00, 1'b0);
      // one frame runs past a full store
      len = (f == 3) ? MAX_SLOTS + 3 : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        if (f != 3 && $urandom_range(9, 0) == 0) send_host_random();
        else send_rx(8'($urandom), 1'b0);
      end
    end
    send_rx(8'($urandom), 1'b1);
    wait_drained();
  endtask

  task automatic test_tx_frames();
    logic [CFG_DATA_W-1:0] limits [5];
    int target;
    int sent;
    limits = '{10'd0, 10'd1023, 10'd23, 10'd24, 10'($urandom_range(60, 25))};
    write_reg(REG_MODE, CFG_DATA_W'(MODE_TX));
    foreach (limits[k]) begin
      write_reg(REG_MAX_TX, limits[k]);
      // a long limit is only run far enough to show no early break
      if (tx_slot_limit > 64) target = 40 + $urandom_range(6, 0);
      else target = tx_slot_limit + 2 + $urandom_range(6, 0);
      sent = 0;
      while (sent < target) begin
        if ($urandom_range(11, 0) == 0) begin
          send_host_random();
        end else if ($urandom_range(31, 0) == 0) begin
          send_rx(8'($urandom), 1'($urandom));
        end else begin
          send_tx_done();
          sent++;
        end
      end
      wait_drained();
    end
  endtask

  task automatic test_mode_switching();
    int n;
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_MODE, 10'($urandom));
      if ($urandom_range(1, 0)) write_reg(REG_MAX_TX, 10'($urandom));
      n = $urandom_range(10, 3);
      repeat (n) send_item(rand_item(cmd_e'($urandom_range(3, 0))));
      wait_drained();
    end
  endtask

  task automatic test_no_idle();
    src_max_gap   = 0;
    sink_max_wait = 0;
    write_reg(REG_MODE, CFG_DATA_W'(MODE_TX));
    repeat (40) begin
      if ($urandom_range(3, 0) == 0) send_host_random();
      else send_tx_done();
    end
    wait_drained();
    src_max_gap   = 14;
    sink_max_wait = 14;
  endtask

  task automatic test_backpressure();
    sink_hold_cycles = 200;
    src_max_gap      = 0;
    repeat (40) begin
      if ($urandom_range(2, 0) == 0) send_host_random();
      else send_tx_done();
    end
    src_max_gap = 14;
    wait_drained();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_MODE;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_host_access();
    test_tx_directed();
    test_rx_directed();
    test_rx_frames();
    test_tx_frames();
    test_mode_switching();
    test_no_idle();
    test_backpressure();
    wait_drained();

    if (mismatches == 0) begin
      $display("dmx512_frame_engine regression: pass");
    end else begin
      $display("dmx512_frame_engine regression: fail");
    end
    $finish;
  end

endmodule

// ===== dmx512_frame_engine.f =====
rtl/dmxfe_pkg.sv
rtl/dmxfe_front.sv
rtl/dmxfe_queue.sv
rtl/dmxfe_back.sv
rtl/dmx512_frame_engine.sv
tb/tb_dmx512_frame_engine.sv
